/* hw/rtl/cbt_pkg.sv */
// cbt_pkg: shared types, constants and helpers for chunk_bitmap_tracker.
// No dependencies.
package cbt_pkg;

   localparam int MAX_CHUNKS = 65536;
   localparam int MAP_BYTES  = (MAX_CHUNKS + 7) / 8;
   localparam int ADDR_W     = $clog2(MAP_BYTES);
   localparam int CNT_W      = 17;

   localparam logic [2:0] ACT_TEST      = 3'd0;
   localparam logic [2:0] ACT_SET       = 3'd1;
   localparam logic [2:0] ACT_CLEAR     = 3'd2;
   localparam logic [2:0] ACT_SET_RANGE = 3'd3;
   localparam logic [2:0] ACT_FIRST_MIS = 3'd4;
   localparam logic [2:0] ACT_LOAD_BYTE = 3'd5;
   localparam logic [2:0] ACT_CLEAR_ALL = 3'd6;

   typedef struct packed {
      logic [2:0]  action;
      logic [15:0] index;
      logic [15:0] index_last;
      logic [12:0] byte_index;
      logic [7:0]  byte_value;
   } req_type;

   typedef struct packed {
      logic             ok;
      logic             present;
      logic [CNT_W-1:0] found_index;
      logic [CNT_W-1:0] have_count;
      logic [CNT_W-1:0] prefix_length;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic check;
      logic sweep_wr;
      logic mem_rd;
      logic modify;
      logic scan_rd;
      logic scan_test;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic req_ok;
      logic is_search;
      logic is_clear_all;
      logic sweep_last;
      logic last_byte;
      logic need_scan;
      logic scan_end;
      logic scan_hit;
   } sts_type;

   function automatic logic [3:0] pop8(input logic [7:0] v);
      logic [3:0] n;
      n = 4'd0;
      for (int i = 0; i < 8; i++) n = n + {3'd0, v[i]};
      return n;
   endfunction

   // index of lowest zero bit; byte assumed not all ones
   function automatic logic [2:0] ffz8(input logic [7:0] v);
      logic [2:0] p;
      p = 3'd0;
      for (int i = 7; i >= 0; i--) if (!v[i]) p = 3'(i);
      return p;
   endfunction

endpackage

/* hw/rtl/cbt_ram.sv */
// cbt_ram: generic single write, single read RAM with registered read.
// No dependencies.
module cbt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8192
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) mem_ff[waddr] <= wdata;
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* hw/rtl/cbt_datapath.sv */
// cbt_datapath: request, count, prefix and scan registers plus the bitmap RAM.
// Depends on cbt_pkg and cbt_ram.
module cbt_datapath (
   input  logic                      clock,
   input  logic                      reset,
   input  cbt_pkg::req_type          req_data,
   input  logic                      csr_we,
   input  logic [cbt_pkg::CNT_W-1:0] csr_wdata,
   input  cbt_pkg::cmd_type          cmd,
   output cbt_pkg::sts_type          sts,
   output cbt_pkg::rsp_type          rsp_data
);

   localparam int AW = cbt_pkg::ADDR_W;
   localparam int CW = cbt_pkg::CNT_W;

   cbt_pkg::req_type req_ff;
   logic [CW-1:0] count_ff, held_ff, held_in, prefix_ff, scan_ff, found_ff;
   logic [AW-1:0] sweep_ff, byte_ff;
   logic          ok_ff, present_ff, scan_pfx_ff, need_scan_ff;

   logic [AW-1:0] start_byte, end_byte, raddr, waddr;
   logic [7:0]    rdata, wdata, new_byte, mask, tail_mask, lo_mask, scanned;
   logic [2:0]    lo, hi, last_bit;
   logic [14:0]   nbytes;
   logic [CW-1:0] idx17, pos, scan_res, load_start;
   logic          we, in_range, range_ok, byte_ok, req_ok, bit_set, mod_ok;
   logic          tail_byte, is_range, scan_need;

   assign idx17      = {1'b0, req_ff.index};
   assign nbytes     = 15'((18'(count_ff) + 18'd7) >> 3);
   assign in_range   = idx17 < count_ff;
   assign range_ok   = (req_ff.index <= req_ff.index_last) &&
                       ({1'b0, req_ff.index_last} < count_ff);
   assign byte_ok    = {2'b00, req_ff.byte_index} < nbytes;
   assign is_range   = req_ff.action == cbt_pkg::ACT_SET_RANGE;
   assign load_start = {1'b0, req_ff.byte_index, 3'b000};

   always_comb begin
      case (req_ff.action)
         cbt_pkg::ACT_TEST, cbt_pkg::ACT_SET, cbt_pkg::ACT_CLEAR: req_ok = in_range;
         cbt_pkg::ACT_SET_RANGE: req_ok = range_ok;
         cbt_pkg::ACT_FIRST_MIS: req_ok = 1'b1;
         cbt_pkg::ACT_LOAD_BYTE: req_ok = byte_ok;
         cbt_pkg::ACT_CLEAR_ALL: req_ok = 1'b1;
         default:                req_ok = 1'b0;
      endcase
   end

   assign start_byte = (req_ff.action == cbt_pkg::ACT_LOAD_BYTE) ? AW'(req_ff.byte_index)
                                                                 : AW'(req_ff.index >> 3);
   assign end_byte   = is_range ? AW'(req_ff.index_last >> 3) : start_byte;
   assign last_bit   = is_range ? req_ff.index_last[2:0] : req_ff.index[2:0];

   // bits of the current byte covered by the request
   assign lo   = (byte_ff == start_byte) ? req_ff.index[2:0] : 3'd0;
   assign hi   = (byte_ff == end_byte) ? last_bit : 3'd7;
   assign mask = (8'hFF << lo) & (8'hFF >> (3'd7 - hi));

   assign tail_byte = (count_ff[2:0] != 3'd0) &&
                      ({2'b00, req_ff.byte_index} == nbytes - 15'd1);
   assign tail_mask = tail_byte ? 8'((9'd1 << count_ff[2:0]) - 9'd1) : 8'hFF;
   assign bit_set   = (rdata & mask) != 8'd0;

   always_comb begin
      new_byte = rdata;
      mod_ok   = 1'b1;
      case (req_ff.action)
         cbt_pkg::ACT_SET: begin
            new_byte = rdata | mask;
            mod_ok   = !bit_set;
         end
         cbt_pkg::ACT_CLEAR: begin
            new_byte = rdata & ~mask;
            mod_ok   = bit_set;
         end
         cbt_pkg::ACT_SET_RANGE: new_byte = rdata | mask;
         cbt_pkg::ACT_LOAD_BYTE: new_byte = req_ff.byte_value & tail_mask;
         default:                new_byte = rdata;
      endcase
   end

   // prefix may grow or shrink only when the write touches it
   always_comb begin
      case (req_ff.action)
         cbt_pkg::ACT_SET:       scan_need = mod_ok && idx17 == prefix_ff;
         cbt_pkg::ACT_SET_RANGE: scan_need = idx17 <= prefix_ff;
         cbt_pkg::ACT_LOAD_BYTE: scan_need = load_start <= prefix_ff;
         default:                scan_need = 1'b0;
      endcase
   end

   assign held_in = held_ff - CW'(cbt_pkg::pop8(rdata)) + CW'(cbt_pkg::pop8(new_byte));

   // scan step: bits below the start point count as held
   assign lo_mask  = 8'((9'd1 << scan_ff[2:0]) - 9'd1);
   assign scanned  = rdata | lo_mask;
   assign pos      = {1'b0, scan_ff[15:3], cbt_pkg::ffz8(scanned)};
   assign scan_res = (pos < count_ff) ? pos : count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         held_ff   <= '0;
         prefix_ff <= '0;
         sweep_ff  <= '0;
      end else if (csr_we) begin
         count_ff  <= (csr_wdata > CW'(cbt_pkg::MAX_CHUNKS)) ? CW'(cbt_pkg::MAX_CHUNKS)
                                                             : csr_wdata;
         held_ff   <= '0;
         prefix_ff <= '0;
         sweep_ff  <= '0;
      end else begin
         if (cmd.sweep_wr) sweep_ff <= sweep_ff + AW'(1);
         if (cmd.capture) begin
            req_ff     <= req_data;
            ok_ff      <= 1'b0;
            present_ff <= 1'b0;
            found_ff   <= '0;
         end
         if (cmd.check) begin
            byte_ff     <= start_byte;
            scan_ff     <= idx17;
            scan_pfx_ff <= 1'b0;
            ok_ff       <= req_ok && (req_ff.action == cbt_pkg::ACT_FIRST_MIS ||
                                      req_ff.action == cbt_pkg::ACT_CLEAR_ALL);
            if (req_ff.action == cbt_pkg::ACT_CLEAR_ALL) begin
               held_ff   <= '0;
               prefix_ff <= '0;
               sweep_ff  <= '0;
            end
         end
         if (cmd.modify) begin
            held_ff <= held_in;
            if (req_ff.action == cbt_pkg::ACT_TEST) present_ff <= bit_set;
            if (req_ff.action != cbt_pkg::ACT_SET_RANGE || byte_ff == end_byte) begin
               ok_ff <= mod_ok;
            end
            if (byte_ff != end_byte) byte_ff <= byte_ff + AW'(1);
            need_scan_ff <= scan_need;
            scan_pfx_ff  <= 1'b1;
            scan_ff      <= (req_ff.action == cbt_pkg::ACT_LOAD_BYTE) ? load_start : prefix_ff;
            if (req_ff.action == cbt_pkg::ACT_CLEAR && mod_ok && idx17 < prefix_ff) begin
               prefix_ff <= idx17;
            end
         end
         if ((cmd.scan_rd && scan_ff >= count_ff) || (cmd.scan_test && scanned != 8'hFF)) begin
            if (scan_pfx_ff) prefix_ff <= cmd.scan_rd ? count_ff : scan_res;
            else             found_ff  <= cmd.scan_rd ? count_ff : scan_res;
         end else if (cmd.scan_test) begin
            scan_ff <= {scan_ff[16:3] + 14'd1, 3'b000};
         end
      end
   end

   assign we    = cmd.sweep_wr || cmd.modify;
   assign waddr = cmd.sweep_wr ? sweep_ff : byte_ff;
   assign wdata = cmd.sweep_wr ? 8'd0 : new_byte;
   assign raddr = cmd.mem_rd ? byte_ff : scan_ff[AW+2:3];

   cbt_ram #(.WIDTH(8), .DEPTH(cbt_pkg::MAP_BYTES)) u_map (
      .clock (clock),
      .we    (we),
      .waddr (waddr),
      .wdata (wdata),
      .raddr (raddr),
      .rdata (rdata)
   );

   assign sts.req_ok       = req_ok;
   assign sts.is_search    = req_ff.action == cbt_pkg::ACT_FIRST_MIS;
   assign sts.is_clear_all = req_ff.action == cbt_pkg::ACT_CLEAR_ALL;
   assign sts.sweep_last   = sweep_ff == AW'(cbt_pkg::MAP_BYTES - 1);
   assign sts.last_byte    = byte_ff == end_byte;
   assign sts.need_scan    = need_scan_ff;
   assign sts.scan_end     = scan_ff >= count_ff;
   assign sts.scan_hit     = scanned != 8'hFF;

   assign rsp_data.ok            = ok_ff;
   assign rsp_data.present       = present_ff;
   assign rsp_data.found_index   = found_ff;
   assign rsp_data.have_count    = held_ff;
   assign rsp_data.prefix_length = prefix_ff;

endmodule

/* hw/rtl/cbt_ctrl.sv */
// cbt_ctrl: sequencer for clearing sweeps, byte read-modify-write and scans.
// Depends on cbt_pkg.
module cbt_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             csr_we,
   input  cbt_pkg::sts_type sts,
   output cbt_pkg::cmd_type cmd,
   output logic             busy,
   output logic             rsp_valid
);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_CLEAR = 4'd1;
   localparam logic [3:0] S_CHECK = 4'd2;
   localparam logic [3:0] S_RD    = 4'd3;
   localparam logic [3:0] S_MOD   = 4'd4;
   localparam logic [3:0] S_POST  = 4'd5;
   localparam logic [3:0] S_SRD   = 4'd6;
   localparam logic [3:0] S_SCHK  = 4'd7;
   localparam logic [3:0] S_RESP  = 4'd8;

   logic [3:0] state_ff, state_in;
   logic       resp_ff, resp_in;

   always_comb begin
      state_in = state_ff;
      resp_in  = resp_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = S_CHECK;
            end
         end
         S_CLEAR: begin
            cmd.sweep_wr = 1'b1;
            if (sts.sweep_last) state_in = resp_ff ? S_RESP : S_IDLE;
         end
         S_CHECK: begin
            cmd.check = 1'b1;
            if (!sts.req_ok) begin
               state_in = S_RESP;
            end else if (sts.is_clear_all) begin
               resp_in  = 1'b1;
               state_in = S_CLEAR;
            end else if (sts.is_search) begin
               state_in = S_SRD;
            end else begin
               state_in = S_RD;
            end
         end
         S_RD: begin
            cmd.mem_rd = 1'b1;
            state_in   = S_MOD;
         end
         S_MOD: begin
            cmd.modify = 1'b1;
            state_in   = sts.last_byte ? S_POST : S_RD;
         end
         S_POST: state_in = sts.need_scan ? S_SRD : S_RESP;
         S_SRD: begin
            cmd.scan_rd = 1'b1;
            state_in    = sts.scan_end ? S_RESP : S_SCHK;
         end
         S_SCHK: begin
            cmd.scan_test = 1'b1;
            state_in      = sts.scan_hit ? S_RESP : S_SRD;
         end
         S_RESP: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
      if (csr_we) begin
         state_in = S_CLEAR;
         resp_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         resp_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         resp_ff  <= resp_in;
      end
   end

   assign busy      = state_ff != S_IDLE;
   assign rsp_valid = state_ff == S_RESP;

   a_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result strobe longer than one cycle");
   a_accept: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("accepted request did not make block busy");
   a_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> busy) else $error("block idle straight after reset");

endmodule

/* hw/rtl/chunk_bitmap_tracker.sv */
// chunk_bitmap_tracker: top level, cbt_ctrl sequencer plus cbt_datapath.
// Test/set/clear/load: check, read, modify, post states; set range repeats read
// and modify per byte touched; first missing alternates scan read and test per
// byte. A set at the held prefix, or a set range or load at or below it, adds a
// prefix scan. Clear all and chunk_count writes sweep all 8192 bytes, one per
// cycle, as does synchronous reset (busy high). Next request taken after strobe.
module chunk_bitmap_tracker (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  cbt_pkg::req_type          req_data,
   output logic                      rsp_valid,
   output cbt_pkg::rsp_type          rsp_data,
   input  logic                      csr_we,
   input  logic [cbt_pkg::CNT_W-1:0] csr_wdata
);

   cbt_pkg::cmd_type cmd;
   cbt_pkg::sts_type sts;

   // sequencer: one RAM access per state, read data registered
   cbt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .csr_we    (csr_we),
      .sts       (sts),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   // bitmap RAM, held count and prefix length kept incrementally
   cbt_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_data  (rsp_data)
   );

endmodule
